// ===== rtl/receiver_gain_hill_climb_assert.svh =====
// Assertion macros used by the receiver gain hill climber core RTL.
`ifndef RECEIVER_GAIN_HILL_CLIMB_ASSERT_SVH
`define RECEIVER_GAIN_HILL_CLIMB_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RGHC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RGHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rghc_pkg.sv =====
// Shared constants, types and helper function of the receiver gain hill climber.
package rghc_pkg;

	localparam int METRIC_BITS = 16;
	localparam int GAIN_BITS = 6;
	localparam int STEP_BITS = 4;
	localparam int SWEEP_BITS = 5;
	localparam int LOST_BITS = 3;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = (GAIN_BITS > SWEEP_BITS) ? GAIN_BITS : SWEEP_BITS;
	localparam int PROD_BITS = STEP_BITS + SWEEP_BITS;
	localparam int PROP_BITS = GAIN_BITS + 2;

	localparam logic [GAIN_BITS-1:0] GAIN_TOP = '1;
	localparam logic [LOST_BITS-1:0] ZERO_RUN_TOP = '1;

	localparam logic [STEP_BITS-1:0] RST_GAIN_STEP = STEP_BITS'(2);
	localparam logic [GAIN_BITS-1:0] RST_GAIN_MAX = GAIN_BITS'(38);
	localparam logic [SWEEP_BITS-1:0] RST_SWEEP_STEPS = SWEEP_BITS'(19);
	localparam logic [LOST_BITS-1:0] RST_LOST_LIMIT = LOST_BITS'(3);
	localparam logic [GAIN_BITS-1:0] RST_FALLBACK_GAIN = GAIN_BITS'(11);

	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_STEP = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_MAX = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_STEPS = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_LOST_LIMIT = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_FALLBACK_GAIN = CFG_IDX_BITS'(4);

	typedef enum logic [2:0] {
		PH_SWEEP = 3'b001,
		PH_HOLD  = 3'b010,
		PH_PROBE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [STEP_BITS-1:0]  gain_step;
		logic [GAIN_BITS-1:0]  gain_max;
		logic [SWEEP_BITS-1:0] sweep_steps;
		logic [LOST_BITS-1:0]  lost_limit;
		logic [GAIN_BITS-1:0]  fallback_gain;
	} cfg_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0] gain;
		logic                 tracking;
		logic                 link_lost;
	} result_t;

	function automatic logic [GAIN_BITS-1:0] sweep_gain(
		input logic [STEP_BITS-1:0]  step,
		input logic [SWEEP_BITS-1:0] k
	);
		logic [PROD_BITS-1:0] prod;
		prod = PROD_BITS'(step) * PROD_BITS'(k);
		if (prod > PROD_BITS'(GAIN_TOP)) begin
			return GAIN_TOP;
		end
		return prod[GAIN_BITS-1:0];
	endfunction

endpackage

// ===== rtl/rghc_core.sv =====
// Sweep and tracking state with the combinational gain update.
`include "receiver_gain_hill_climb_assert.svh"

module rghc_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rghc_pkg::cfg_t                  cfg,
	input  logic                            advance,
	input  logic [rghc_pkg::METRIC_BITS-1:0] metric_s1,
	output rghc_pkg::result_t               res
);
	import rghc_pkg::*;

	phase_t                phase_q, phase_d;
	logic [SWEEP_BITS-1:0] sweep_idx_q, sweep_idx_d;
	logic [METRIC_BITS-1:0] peak_metric_q, peak_metric_d;
	logic [GAIN_BITS-1:0]  peak_gain_q, peak_gain_d;
	logic [GAIN_BITS-1:0]  held_gain_q, held_gain_d;
	logic [METRIC_BITS-1:0] held_metric_q, held_metric_d;
	logic [GAIN_BITS-1:0]  prop_gain_q, prop_gain_d;
	logic                  going_down_q, going_down_d;
	logic [LOST_BITS-1:0]  zero_run_q, zero_run_d;

	logic signed [PROP_BITS-1:0] prop_raw;
	logic [GAIN_BITS-1:0]        prop_clamped;
	logic [GAIN_BITS-1:0]        cur_gain;
	logic [SWEEP_BITS-1:0]       idx_inc;
	logic [GAIN_BITS-1:0]        adv_gain;
	logic                        better;
	logic [LOST_BITS-1:0]        run_next;

	always_comb begin
		if (going_down_q) begin
			prop_raw = $signed(PROP_BITS'(held_gain_q)) - $signed(PROP_BITS'(cfg.gain_step));
		end else begin
			prop_raw = $signed(PROP_BITS'(held_gain_q)) + $signed(PROP_BITS'(cfg.gain_step));
		end
		priority if (prop_raw < 0) begin
			prop_clamped = '0;
		end else if (prop_raw > $signed(PROP_BITS'(cfg.gain_max))) begin
			prop_clamped = cfg.gain_max;
		end else begin
			prop_clamped = prop_raw[GAIN_BITS-1:0];
		end
	end

	assign cur_gain = sweep_gain(cfg.gain_step, sweep_idx_q);
	assign idx_inc  = sweep_idx_q + SWEEP_BITS'(1);
	assign adv_gain = sweep_gain(cfg.gain_step, idx_inc);

	always_comb begin
		phase_d       = phase_q;
		sweep_idx_d   = sweep_idx_q;
		peak_metric_d = peak_metric_q;
		peak_gain_d   = peak_gain_q;
		held_gain_d   = held_gain_q;
		held_metric_d = held_metric_q;
		prop_gain_d   = prop_gain_q;
		going_down_d  = going_down_q;
		zero_run_d    = zero_run_q;
		better        = 1'b0;
		run_next      = zero_run_q;
		res           = '0;

		unique case (phase_q)
			PH_HOLD: begin
				held_metric_d = metric_s1;
				prop_gain_d   = prop_clamped;
				phase_d       = PH_PROBE;
				res.gain      = prop_clamped;
			end
			PH_PROBE: begin
				better = metric_s1 > held_metric_q;
				if (better) begin
					held_gain_d = prop_gain_q;
				end else begin
					going_down_d = ~going_down_q;
				end
				if (metric_s1 == '0) begin
					run_next = (zero_run_q == ZERO_RUN_TOP) ? zero_run_q
						: zero_run_q + LOST_BITS'(1);
				end else begin
					run_next = '0;
				end
				zero_run_d = run_next;
				if (run_next >= cfg.lost_limit) begin
					phase_d       = PH_SWEEP;
					sweep_idx_d   = SWEEP_BITS'(1);
					peak_metric_d = '0;
					peak_gain_d   = cfg.fallback_gain;
					going_down_d  = 1'b0;
					zero_run_d    = '0;
					res.link_lost = 1'b1;
					res.gain      = sweep_gain(cfg.gain_step, SWEEP_BITS'(1));
				end else begin
					phase_d  = PH_HOLD;
					res.gain = better ? prop_gain_q : held_gain_q;
				end
			end
			default: begin
				better = metric_s1 > peak_metric_q;
				if (better) begin
					peak_metric_d = metric_s1;
					peak_gain_d   = cur_gain;
				end
				if (sweep_idx_q >= cfg.sweep_steps) begin
					held_gain_d = (peak_metric_d == '0) ? cfg.fallback_gain : peak_gain_d;
					phase_d     = PH_HOLD;
					res.gain    = held_gain_d;
				end else begin
					phase_d     = PH_SWEEP;
					sweep_idx_d = idx_inc;
					res.gain    = adv_gain;
				end
			end
		endcase
		res.tracking = (phase_d != PH_SWEEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SWEEP;
			sweep_idx_q   <= SWEEP_BITS'(1);
			peak_metric_q <= '0;
			peak_gain_q   <= RST_FALLBACK_GAIN;
			held_gain_q   <= '0;
			held_metric_q <= '0;
			prop_gain_q   <= '0;
			going_down_q  <= 1'b0;
			zero_run_q    <= '0;
		end else if (advance) begin
			phase_q       <= phase_d;
			sweep_idx_q   <= sweep_idx_d;
			peak_metric_q <= peak_metric_d;
			peak_gain_q   <= peak_gain_d;
			held_gain_q   <= held_gain_d;
			held_metric_q <= held_metric_d;
			prop_gain_q   <= prop_gain_d;
			going_down_q  <= going_down_d;
			zero_run_q    <= zero_run_d;
		end
	end

	`RGHC_ASSERT_NEXT(a_lost_restarts, advance && res.link_lost,
		phase_q == PH_SWEEP && sweep_idx_q == SWEEP_BITS'(1) && zero_run_q == '0,
		"link loss did not restart the sweep")
	`RGHC_ASSERT_NEXT(a_tracking_flag, advance,
		(phase_q != PH_SWEEP) == $past(res.tracking),
		"tracking flag disagrees with the phase taken")
	`RGHC_ASSERT_NEXT(a_hold_to_probe, advance && phase_q == PH_HOLD,
		phase_q == PH_PROBE && prop_gain_q == $past(res.gain),
		"held measurement did not issue the proposal")
	`RGHC_ASSERT_IMPL(a_lost_not_tracking, res.link_lost, !res.tracking,
		"link loss reported while tracking")

endmodule

// ===== rtl/receiver_gain_hill_climb.sv =====
// Receiver gain hill climber top level: configuration registers and handshake pipeline.
//
// Each transaction carries one link-quality metric measured at the last commanded gain
// and returns one result with the next gain. A metric is accepted every cycle while
// results are taken; it is held in the input register, and its result is loaded into
// the result register, raising out_valid, when the core advances past a taken result.
// The rate is set by the combinational state update in rghc_core. While a
// result waits, one more metric can enter the input register before in_ready drops.
// Write configuration registers only while no transaction is in flight.
module receiver_gain_hill_climb (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rghc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rghc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rghc_pkg::METRIC_BITS-1:0]   metric,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rghc_pkg::GAIN_BITS-1:0]     gain,
	output logic                               tracking,
	output logic                               link_lost
);
	import rghc_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic [METRIC_BITS-1:0] metric_s1;
	logic                   advance;
	result_t                res;
	result_t                res_q;
	logic                   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_step     <= RST_GAIN_STEP;
			cfg_q.gain_max      <= RST_GAIN_MAX;
			cfg_q.sweep_steps   <= RST_SWEEP_STEPS;
			cfg_q.lost_limit    <= RST_LOST_LIMIT;
			cfg_q.fallback_gain <= RST_FALLBACK_GAIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GAIN_STEP:     cfg_q.gain_step     <= cfg_wdata[STEP_BITS-1:0];
				REG_GAIN_MAX:      cfg_q.gain_max      <= cfg_wdata[GAIN_BITS-1:0];
				REG_SWEEP_STEPS:   cfg_q.sweep_steps   <= cfg_wdata[SWEEP_BITS-1:0];
				REG_LOST_LIMIT:    cfg_q.lost_limit    <= cfg_wdata[LOST_BITS-1:0];
				REG_FALLBACK_GAIN: cfg_q.fallback_gain <= cfg_wdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			metric_s1 <= metric;
		end
	end

	rghc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.advance   (advance),
		.metric_s1 (metric_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign gain      = res_q.gain;
	assign tracking  = res_q.tracking;
	assign link_lost = res_q.link_lost;

endmodule

// ===== dv/receiver_gain_hill_climb_checker.sv =====
`timescale 1ns / 100ps
// Gain predictor and result comparator for the receiver gain hill climber.
module receiver_gain_hill_climb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rghc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rghc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [rghc_pkg::METRIC_BITS-1:0]   metric,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [rghc_pkg::GAIN_BITS-1:0]     gain,
	input  logic                               tracking,
	input  logic                               link_lost,
	output int                                 error_count,
	output int                                 expected_depth
);
	import rghc_pkg::*;

	cfg_t                   cfg;
	phase_t                 phase;
	logic [SWEEP_BITS-1:0]  sweep_idx;
	logic [METRIC_BITS-1:0] peak_metric;
	logic [METRIC_BITS-1:0] held_metric;
	logic [GAIN_BITS-1:0]   peak_gain;
	logic [GAIN_BITS-1:0]   held_gain;
	logic [GAIN_BITS-1:0]   proposed_gain;
	logic                   going_down;
	logic [LOST_BITS-1:0]   zero_run;
	result_t                gain_queue[$];
	int                     mismatches = 0;

	assign error_count = mismatches;

	function automatic logic [GAIN_BITS-1:0] ladder_gain(input int k);
		int prod;
		prod = int'(cfg.gain_step) * k;
		if (prod > int'(GAIN_TOP)) begin
			return GAIN_TOP;
		end
		return prod[GAIN_BITS-1:0];
	endfunction

	task automatic restart_sweep();
		phase = PH_SWEEP;
		sweep_idx = SWEEP_BITS'(1);
		peak_metric = '0;
		peak_gain = cfg.fallback_gain;
		going_down = 1'b0;
		zero_run = '0;
	endtask

	task automatic predict_gain(input logic [METRIC_BITS-1:0] m, output result_t r);
		int prop_sum;
		logic [GAIN_BITS-1:0] step_gain;
		r.link_lost = 1'b0;
		case (phase)
			PH_HOLD: begin
				held_metric = m;
				if (going_down) begin
					prop_sum = int'(held_gain) - int'(cfg.gain_step);
				end else begin
					prop_sum = int'(held_gain) + int'(cfg.gain_step);
				end
				if (prop_sum < 0) begin
					prop_sum = 0;
				end
				if (prop_sum > int'(cfg.gain_max)) begin
					prop_sum = int'(cfg.gain_max);
				end
				proposed_gain = prop_sum[GAIN_BITS-1:0];
				phase = PH_PROBE;
				r.gain = proposed_gain;
			end
			PH_PROBE: begin
				if (m > held_metric) begin
					held_gain = proposed_gain;
				end else begin
					going_down = ~going_down;
				end
				if (m == '0) begin
					if (zero_run != ZERO_RUN_TOP) begin
						zero_run = zero_run + 1'b1;
					end
				end else begin
					zero_run = '0;
				end
				if (zero_run >= cfg.lost_limit) begin
					restart_sweep();
					r.link_lost = 1'b1;
					r.gain = ladder_gain(1);
				end else begin
					phase = PH_HOLD;
					r.gain = held_gain;
				end
			end
			default: begin
				step_gain = ladder_gain(int'(sweep_idx));
				if (m > peak_metric) begin
					peak_metric = m;
					peak_gain = step_gain;
				end
				if (sweep_idx >= cfg.sweep_steps) begin
					held_gain = (peak_metric == '0) ? cfg.fallback_gain : peak_gain;
					phase = PH_HOLD;
					r.gain = held_gain;
				end else begin
					sweep_idx = sweep_idx + 1'b1;
					r.gain = ladder_gain(int'(sweep_idx));
				end
			end
		endcase
		r.tracking = (phase != PH_SWEEP);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t seen;
		if (!arst_n) begin
			cfg.gain_step = RST_GAIN_STEP;
			cfg.gain_max = RST_GAIN_MAX;
			cfg.sweep_steps = RST_SWEEP_STEPS;
			cfg.lost_limit = RST_LOST_LIMIT;
			cfg.fallback_gain = RST_FALLBACK_GAIN;
			held_gain = '0;
			held_metric = '0;
			proposed_gain = '0;
			restart_sweep();
			gain_queue.delete();
			expected_depth <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GAIN_STEP:     cfg.gain_step = cfg_wdata[STEP_BITS-1:0];
					REG_GAIN_MAX:      cfg.gain_max = cfg_wdata[GAIN_BITS-1:0];
					REG_SWEEP_STEPS:   cfg.sweep_steps = cfg_wdata[SWEEP_BITS-1:0];
					REG_LOST_LIMIT:    cfg.lost_limit = cfg_wdata[LOST_BITS-1:0];
					REG_FALLBACK_GAIN: cfg.fallback_gain = cfg_wdata[GAIN_BITS-1:0];
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				seen = {gain, tracking, link_lost};
				if (gain_queue.size() == 0) begin
					$display("%0t unexpected result: gain %0d tracking %0b link_lost %0b",
						$time, seen.gain, seen.tracking, seen.link_lost);
					mismatches++;
				end else begin
					want = gain_queue.pop_front();
					if (seen.gain !== want.gain) begin
						$display("%0t gain mismatch: expected %0d, actual %0d",
							$time, want.gain, seen.gain);
						mismatches++;
					end
					if (seen.tracking !== want.tracking) begin
						$display("%0t tracking mismatch: expected %0b, actual %0b",
							$time, want.tracking, seen.tracking);
						mismatches++;
					end
					if (seen.link_lost !== want.link_lost) begin
						$display("%0t link_lost mismatch: expected %0b, actual %0b",
							$time, want.link_lost, seen.link_lost);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_gain(metric, want);
				gain_queue.push_back(want);
			end
			expected_depth <= gain_queue.size();
		end
	end

endmodule

// ===== dv/receiver_gain_hill_climb_test.sv =====
`timescale 1ns / 100ps
// Stimulus, pacing and verdict for the receiver gain hill climber.
module receiver_gain_hill_climb_test;
	import rghc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_GAP = 18;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 45;
	localparam int ZERO_BURST = 16;
	localparam int REG_COUNT = 5;
	localparam int FIXED_PLANS = 5;
	localparam int RANDOM_PLANS = 6;
	localparam int CFG_BITS = $bits(cfg_t);

	typedef enum int {
		PACE_FULL,
		PACE_RANDOM,
		PACE_BURSTY
	} pace_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [METRIC_BITS-1:0]   metric = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b1;
	logic [GAIN_BITS-1:0]     gain;
	logic                     tracking;
	logic                     link_lost;
	int                       error_count;
	int                       expected_depth;
	int                       cycle_count = 0;
	pace_t                    send_pace = PACE_FULL;
	pace_t                    recv_pace = PACE_FULL;

	logic [METRIC_BITS-1:0] opening_metrics [24] = '{
		16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF,
		16'h0000, 16'h0100, 16'h00FF, 16'hFFFE, 16'h1234, 16'h0000, 16'h4000, 16'h2000,
		16'hFFFF, 16'h0002, 16'h0001, 16'h0064, 16'h00C8, 16'h00C8, 16'h0000, 16'h0000
	};

	cfg_t fixed_plans [FIXED_PLANS] = '{
		'{4'd8, 6'd63, 5'd31, 3'd7, 6'd63},
		'{4'd1, 6'd0, 5'd1, 3'd1, 6'd0},
		'{4'd0, 6'd20, 5'd0, 3'd0, 6'd5},
		'{4'd15, 6'd10, 5'd5, 3'd2, 6'd40},
		'{4'd3, 6'd63, 5'd1, 3'd7, 6'd0}
	};

	always #2 clk = ~clk;

	receiver_gain_hill_climb dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.metric    (metric),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gain      (gain),
		.tracking  (tracking),
		.link_lost (link_lost)
	);

	receiver_gain_hill_climb_checker gain_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.metric         (metric),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.gain           (gain),
		.tracking       (tracking),
		.link_lost      (link_lost),
		.error_count    (error_count),
		.expected_depth (expected_depth)
	);

	function automatic int draw_gap(input pace_t pace);
		case (pace)
			PACE_FULL:   return 0;
			PACE_RANDOM: return $urandom_range(0, MAX_GAP);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
		endcase
	endfunction

	function automatic logic [METRIC_BITS-1:0] draw_metric();
		case ($urandom_range(0, 9))
			0, 1, 2: return '0;
			3, 4:    return METRIC_BITS'($urandom_range(0, 3));
			5:       return '1;
			default: return METRIC_BITS'($urandom);
		endcase
	endfunction

	task automatic send_metric(input logic [METRIC_BITS-1:0] value);
		int gap;
		gap = draw_gap(send_pace);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		metric <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_depth != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		write_reg(REG_GAIN_STEP, {2'($urandom), c.gain_step});
		write_reg(REG_GAIN_MAX, c.gain_max);
		write_reg(REG_SWEEP_STEPS, {1'($urandom), c.sweep_steps});
		write_reg(REG_LOST_LIMIT, {3'($urandom), c.lost_limit});
		write_reg(REG_FALLBACK_GAIN, c.fallback_gain);
		write_reg(CFG_IDX_BITS'(REG_COUNT + $urandom_range(0, 2)), CFG_DATA_BITS'($urandom));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase();
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 15 == 0) begin
				send_pace = pace_t'($urandom_range(0, 2));
			end
			if (i == PHASE_ITEMS / 2) begin
				drain();
			end
			if ($urandom_range(0, PHASE_ITEMS - 1) == 0) begin
				repeat (ZERO_BURST) send_metric('0);
			end else begin
				send_metric(draw_metric());
			end
		end
		drain();
	endtask

	initial begin : result_sink
		int stall;
		int run_left;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (run_left == 0) begin
					recv_pace = pace_t'($urandom_range(0, 2));
					run_left = $urandom_range(20, 80);
				end
				run_left--;
				stall = draw_gap(recv_pace);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("receiver_gain_hill_climb test failed");
		$finish;
	end

	initial begin : stimulus
		cfg_t plan;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening_metrics[i]) begin
			send_metric(opening_metrics[i]);
		end
		drain();
		foreach (fixed_plans[i]) begin
			apply_cfg(fixed_plans[i]);
			run_phase();
		end
		repeat (RANDOM_PLANS) begin
			plan = CFG_BITS'($urandom);
			apply_cfg(plan);
			run_phase();
		end
		if (error_count == 0) begin
			$display("receiver_gain_hill_climb test passed");
		end else begin
			$display("receiver_gain_hill_climb test failed");
		end
		$finish;
	end

endmodule
